[hw/rtl/bfa_pkg.sv]
// Shared types, codes and defaults for the bitmap frame allocator.
// Used by every module under hw/rtl except bfa_ram; depends on nothing else.
package bfa_pkg;

   localparam int ADDR_BITS        = 32;
   localparam int LEN_BITS         = 17;
   localparam int STATUS_BITS      = 2;
   localparam int FRAME_COUNT_BITS = 17;
   localparam int CSR_INDEX_BITS   = 2;

   // Bitmap word geometry
   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;

   localparam int MAX_FRAMES_DEF  = 65536;
   localparam int FRAME_BYTES_DEF = 4096;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_COUNT  = 2'd1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FAIL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic                 req_type;
      logic [LEN_BITS-1:0]  run_length;
      logic [ADDR_BITS-1:0] free_address;
   } bfa_req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]   alloc_address;
      logic [STATUS_BITS-1:0] status;
   } bfa_rsp_type;

   // Controller to datapath strobes
   typedef struct packed {
      logic load_req;
      logic clr_step;
      logic scan_init;
      logic scan_read;
      logic word_eval;
      logic bit_step;
      logic mark_init;
      logic mark_read;
      logic mark_write;
      logic addr_mul;
      logic addr_add;
      logic div_start;
      logic free_read;
      logic free_write;
      logic set_fail;
      logic set_range;
      logic set_done;
   } bfa_cmd_type;

   // Datapath to controller flags
   typedef struct packed {
      logic clr_last;
      logic is_free;
      logic len_bad;
      logic scan_end;
      logic word_free;
      logic word_full;
      logic word_fits;
      logic bit_hit;
      logic bit_last;
      logic mark_last;
      logic addr_low;
      logic div_done;
      logic idx_bad;
   } bfa_sts_type;

endpackage

[hw/rtl/bfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/bfa_div.sv]
// Division of a frame offset by the constant frame size, by reciprocal multiplication.
// Depends on bfa_pkg.
module bfa_div import bfa_pkg::*; #(
   parameter int DIVISOR = FRAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ADDR_BITS-1:0] dividend,
   output logic                 busy,
   output logic [ADDR_BITS-1:0] quotient
);

   // q = (t + ((x - t) >> SH1)) >> SH2 with t the high half of x * MULT;
   // exact for every 32-bit x, and a plain shift when DIVISOR is a power of two
   localparam int LOG_D = $clog2(DIVISOR);
   localparam int SH1   = (LOG_D > 0) ? 1 : 0;
   localparam int SH2   = (LOG_D > 0) ? LOG_D - 1 : 0;
   localparam longint unsigned MULT_WIDE =
      (((64'd1 << ADDR_BITS) * ((64'd1 << LOG_D) - 64'(DIVISOR))) / 64'(DIVISOR)) + 64'd1;
   localparam logic [ADDR_BITS-1:0] MULT = ADDR_BITS'(MULT_WIDE);

   localparam logic [1:0] STG_IDLE = 2'd0;
   localparam logic [1:0] STG_MUL  = 2'd1;
   localparam logic [1:0] STG_FIX  = 2'd2;

   logic [1:0]             stage_ff, stage_in;
   logic [ADDR_BITS-1:0]   num_ff, num_in;
   logic [ADDR_BITS-1:0]   hi_ff, hi_in;
   logic [ADDR_BITS-1:0]   quo_ff, quo_in;
   logic [2*ADDR_BITS-1:0] product;
   logic [ADDR_BITS-1:0]   adjusted;

   assign product  = (2*ADDR_BITS)'(num_ff) * (2*ADDR_BITS)'(MULT);
   assign adjusted = hi_ff + ((num_ff - hi_ff) >> SH1);

   always_comb begin
      stage_in = stage_ff;
      num_in   = num_ff;
      hi_in    = hi_ff;
      quo_in   = quo_ff;
      if (start) begin
         num_in   = dividend;
         stage_in = STG_MUL;
      end else begin
         unique case (stage_ff)
            STG_MUL: begin
               hi_in    = product[2*ADDR_BITS-1:ADDR_BITS];
               stage_in = STG_FIX;
            end
            STG_FIX: begin
               quo_in   = adjusted >> SH2;
               stage_in = STG_IDLE;
            end
            default: begin
               stage_in = STG_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STG_IDLE;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      hi_ff  <= hi_in;
      quo_ff <= quo_in;
   end

   assign busy     = stage_ff != STG_IDLE;
   assign quotient = quo_ff;

endmodule

[hw/rtl/bfa_datapath.sv]
// Datapath: config registers, bitmap RAM, run scan, mark, address and free logic.
// Depends on bfa_pkg, bfa_ram and bfa_div.
module bfa_datapath import bfa_pkg::*; #(
   parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ADDR_BITS-1:0]      csr_wdata,
   input  bfa_req_type               req_data,
   input  bfa_cmd_type               cmd,
   output bfa_sts_type               sts,
   output bfa_rsp_type               rsp_data
);

   localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PW    = AW + 1;
   localparam int FIW   = AW + WORD_SHIFT;
   localparam int CW    = $clog2(MAX_FRAMES + 1);
   localparam int SW    = CW + 6;

   logic [ADDR_BITS-1:0]        base_ff, base_in;
   logic [FRAME_COUNT_BITS-1:0] count_ff, count_in;
   bfa_req_type                 req_ff, req_in;
   logic [PW-1:0]               ptr_ff, ptr_in;
   logic [WORD_SHIFT-1:0]       bit_ff, bit_in;
   logic [SW-1:0]               run_ff, run_in;
   logic [FIW-1:0]              start_ff, start_in;
   logic [FIW-1:0]              end_ff, end_in;
   logic [WORD_BITS-1:0]        word_ff, word_in;
   logic [ADDR_BITS-1:0]        prod_ff, prod_in;
   logic [ADDR_BITS-1:0]        addr_ff, addr_in;
   logic [STATUS_BITS-1:0]      status_ff, status_in;

   logic [CW-1:0]          eff_n;
   logic [SW-1:0]          n_w, len_w, word_base_w;
   logic [WORD_BITS-1:0]   vmask, eval_word, rd_data, mark_mask, ram_wdata;
   logic [WORD_SHIFT-1:0]  mark_lo, mark_hi, free_bit;
   logic [FIW-1:0]         word_frame, cur_frame;
   logic [AW-1:0]          free_word, ram_raddr, ram_waddr;
   logic                   ram_re, ram_we, div_busy;
   logic [ADDR_BITS-1:0]   quotient;

   assign eff_n = (32'(count_ff) > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(count_ff);
   assign n_w         = SW'(eff_n);
   assign len_w       = SW'(req_ff.run_length);
   assign word_base_w = SW'({ptr_ff, {WORD_SHIFT{1'b0}}});
   assign word_frame  = {ptr_ff[AW-1:0], {WORD_SHIFT{1'b0}}};
   assign cur_frame   = {ptr_ff[AW-1:0], bit_ff};

   // Frames at or beyond the effective count look used
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         vmask[b] = (word_base_w + SW'(b)) < n_w;
      end
   end
   assign eval_word = rd_data | ~vmask;

   assign mark_lo = (ptr_ff[AW-1:0] == start_ff[FIW-1:WORD_SHIFT]) ?
                    start_ff[WORD_SHIFT-1:0] : '0;
   assign mark_hi = sts.mark_last ? end_ff[WORD_SHIFT-1:0] : '1;
   assign mark_mask = ({WORD_BITS{1'b1}} << mark_lo) &
                      ({WORD_BITS{1'b1}} >> (WORD_SHIFT'(WORD_BITS - 1) - mark_hi));

   assign free_word = quotient[WORD_SHIFT +: AW];
   assign free_bit  = quotient[WORD_SHIFT-1:0];

   // Status flags
   assign sts.clr_last  = ptr_ff[AW-1:0] == AW'(WORDS - 1);
   assign sts.is_free   = req_ff.req_type == REQ_FREE;
   assign sts.len_bad   = (req_ff.run_length == '0) ||
                          (32'(req_ff.run_length) > 32'(eff_n));
   assign sts.scan_end  = word_base_w >= n_w;
   assign sts.word_free = eval_word == '0;
   assign sts.word_full = &eval_word;
   assign sts.word_fits = (run_ff + SW'(WORD_BITS)) >= len_w;
   assign sts.bit_hit   = !word_ff[bit_ff] && ((run_ff + SW'(1)) == len_w);
   assign sts.bit_last  = bit_ff == WORD_SHIFT'(WORD_BITS - 1);
   assign sts.mark_last = ptr_ff[AW-1:0] == end_ff[FIW-1:WORD_SHIFT];
   assign sts.addr_low  = req_ff.free_address < base_ff;
   assign sts.div_done  = !div_busy;
   assign sts.idx_bad   = quotient >= 32'(eff_n);

   always_comb begin
      base_in   = base_ff;
      count_in  = count_ff;
      req_in    = req_ff;
      ptr_in    = ptr_ff;
      bit_in    = bit_ff;
      run_in    = run_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      word_in   = word_ff;
      prod_in   = prod_ff;
      addr_in   = addr_ff;
      status_in = status_ff;

      if (csr_write) begin
         if (csr_index == CSR_BASE_ADDRESS) begin
            base_in = csr_wdata;
         end
         if (csr_index == CSR_FRAME_COUNT) begin
            count_in = csr_wdata[FRAME_COUNT_BITS-1:0];
         end
      end

      if (cmd.load_req) begin
         req_in = req_data;
      end
      if (cmd.clr_step) begin
         ptr_in = sts.clr_last ? '0 : ptr_ff + PW'(1);
      end
      if (cmd.scan_init) begin
         ptr_in = '0;
         run_in = '0;
      end
      if (cmd.word_eval) begin
         if (sts.word_free) begin
            if (run_ff == '0) begin
               start_in = word_frame;
            end
            if (!sts.word_fits) begin
               run_in = run_ff + SW'(WORD_BITS);
               ptr_in = ptr_ff + PW'(1);
            end
         end else if (sts.word_full) begin
            run_in = '0;
            ptr_in = ptr_ff + PW'(1);
         end else begin
            word_in = eval_word;
            bit_in  = '0;
         end
      end
      if (cmd.bit_step) begin
         if (!word_ff[bit_ff]) begin
            if (run_ff == '0) begin
               start_in = cur_frame;
            end
            run_in = run_ff + SW'(1);
         end else begin
            run_in = '0;
         end
         bit_in = bit_ff + WORD_SHIFT'(1);
         if (sts.bit_last) begin
            ptr_in = ptr_ff + PW'(1);
         end
      end
      if (cmd.mark_init) begin
         end_in = FIW'(SW'(start_ff) + len_w - SW'(1));
         ptr_in = PW'(start_ff[FIW-1:WORD_SHIFT]);
      end
      if (cmd.mark_write) begin
         ptr_in = ptr_ff + PW'(1);
      end
      if (cmd.addr_mul) begin
         prod_in = ADDR_BITS'(start_ff) * ADDR_BITS'(FRAME_BYTES);
      end
      if (cmd.addr_add) begin
         addr_in   = base_ff + prod_ff;
         status_in = ST_DONE;
      end
      if (cmd.set_fail) begin
         addr_in   = '0;
         status_in = ST_FAIL;
      end
      if (cmd.set_range) begin
         addr_in   = '0;
         status_in = ST_RANGE;
      end
      if (cmd.set_done) begin
         addr_in   = '0;
         status_in = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         base_ff  <= base_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      bit_ff    <= bit_in;
      run_ff    <= run_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      word_ff   <= word_in;
      prod_ff   <= prod_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
   end

   // Bitmap RAM ports
   assign ram_re    = cmd.scan_read | cmd.mark_read | cmd.free_read;
   assign ram_raddr = cmd.free_read ? free_word : ptr_ff[AW-1:0];
   assign ram_we    = cmd.clr_step | cmd.mark_write | cmd.free_write;
   assign ram_waddr = cmd.free_write ? free_word : ptr_ff[AW-1:0];

   always_comb begin
      priority if (cmd.clr_step) begin
         ram_wdata = '0;
      end else if (cmd.mark_write) begin
         ram_wdata = rd_data | mark_mask;
      end else begin
         ram_wdata = rd_data & ~(WORD_BITS'(1) << free_bit);
      end
   end

   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_data)
   );

   bfa_div #(
      .DIVISOR (FRAME_BYTES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (req_ff.free_address - base_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign rsp_data.alloc_address = addr_ff;
   assign rsp_data.status        = status_ff;

endmodule

[hw/rtl/bfa_ctrl.sv]
// Controller state machine: sequences clear, scan, mark, address and free steps.
// Depends on bfa_pkg.
module bfa_ctrl import bfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  bfa_sts_type sts,
   output logic        busy,
   output logic        rsp_strobe,
   output bfa_cmd_type cmd
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_CHECK    = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_EV  = 4'd4;
   localparam logic [3:0] S_BIT      = 4'd5;
   localparam logic [3:0] S_MARK_SET = 4'd6;
   localparam logic [3:0] S_MARK_RD  = 4'd7;
   localparam logic [3:0] S_MARK_WR  = 4'd8;
   localparam logic [3:0] S_MUL      = 4'd9;
   localparam logic [3:0] S_ADD      = 4'd10;
   localparam logic [3:0] S_DIV_WAIT = 4'd11;
   localparam logic [3:0] S_FREE_RD  = 4'd12;
   localparam logic [3:0] S_FREE_WR  = 4'd13;
   localparam logic [3:0] S_RESP     = 4'd14;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_free) begin
               if (sts.addr_low) begin
                  cmd.set_range = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV_WAIT;
               end
            end else if (sts.len_bad) begin
               cmd.set_fail = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (sts.scan_end) begin
               cmd.set_fail = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cmd.word_eval = 1'b1;
            if (sts.word_free && sts.word_fits) begin
               state_in = S_MARK_SET;
            end else if (sts.word_free || sts.word_full) begin
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_BIT;
            end
         end
         S_BIT: begin
            cmd.bit_step = 1'b1;
            if (sts.bit_hit) begin
               state_in = S_MARK_SET;
            end else if (sts.bit_last) begin
               state_in = S_SCAN_RD;
            end
         end
         S_MARK_SET: begin
            cmd.mark_init = 1'b1;
            state_in      = S_MARK_RD;
         end
         S_MARK_RD: begin
            cmd.mark_read = 1'b1;
            state_in      = S_MARK_WR;
         end
         S_MARK_WR: begin
            cmd.mark_write = 1'b1;
            state_in       = sts.mark_last ? S_MUL : S_MARK_RD;
         end
         S_MUL: begin
            cmd.addr_mul = 1'b1;
            state_in     = S_ADD;
         end
         S_ADD: begin
            cmd.addr_add = 1'b1;
            state_in     = S_RESP;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) begin
               if (sts.idx_bad) begin
                  cmd.set_range = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_FREE_RD;
               end
            end
         end
         S_FREE_RD: begin
            cmd.free_read = 1'b1;
            state_in      = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.free_write = 1'b1;
            cmd.set_done   = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_RESP;

endmodule

[hw/rtl/bitmap_frame_allocator.sv]
// Top level of the first-fit bitmap frame allocator.
// Depends on bfa_pkg, bfa_ctrl and bfa_datapath (which holds bfa_ram and bfa_div).

// A request is taken when start is high while busy is low; busy then stays high
// until the single result has been shown. The result is shown with rsp_strobe high
// for exactly one cycle on rsp_data and cannot be held off, so capture it then.
// After reset the block sweeps the bitmap RAM to zero, one 32-frame word per
// cycle, with busy high; csr writes are accepted throughout. An allocate first
// checks the length, then scans the map one RAM word at a time: a word that is
// wholly free or wholly used is taken whole, a word that mixes both is walked
// bit by bit. Marking the run takes a setup step plus a read and a write per
// word, then the address is formed by a multiply and an add, and the result
// follows. The scan over the RAM read port sets the worst case, for a badly
// fragmented map. A free derives the frame index by reciprocal multiplication,
// then does a read-modify-write of its bitmap word. A bad request length or a
// free below base is answered straight from the check, a free beyond the last
// frame after the division.
module bitmap_frame_allocator import bfa_pkg::*; #(
   parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request transaction
   input  logic                      start,
   output logic                      busy,
   input  bfa_req_type               req_data,
   // result transaction
   output logic                      rsp_strobe,
   output bfa_rsp_type               rsp_data,
   // configuration write transaction
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ADDR_BITS-1:0]      csr_wdata
);

   bfa_cmd_type cmd;
   bfa_sts_type sts;
   logic        csr_write;

   // Registers are simple flops: always take the write
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (sts),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   bfa_datapath #(
      .MAX_FRAMES  (MAX_FRAMES),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

   // Return to idle right after the result cycle
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("busy still high after result");

   // An accepted request must hold the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // Only one writer drives the bitmap RAM at a time
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.mark_write, cmd.free_write}))
      else $error("conflicting bitmap writes");

   // Ignored frees carry a zero address
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == ST_RANGE)) |-> (rsp_data.alloc_address == '0))
      else $error("range status with nonzero address");

endmodule
